// ===== rtl/core/blr_pkg.sv =====
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  localparam int unsigned CoordBits = 11;
  localparam int unsigned ColorBits = 16;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic x_decrement;
    logic y_decrement;
    logic x_major;
  } dir_t;

endpackage

`default_nettype wire

// ===== rtl/core/blr_if.sv =====
// Valid/ready channel interfaces: command beats in, pixel beats out.
// Depends on blr_pkg for the default coordinate and color widths.
`timescale 1ns / 1ps
`default_nettype none

interface blr_cmd_if #(
  parameter int unsigned COORD_BITS = blr_pkg::CoordBits
);
  import blr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [ColorBits-1:0]  color;

  modport source (
    output valid, command, x_start, y_start, x_end, y_end, color,
    input  ready
  );

  modport sink (
    input  valid, command, x_start, y_start, x_end, y_end, color,
    output ready
  );
endinterface

interface blr_pix_if #(
  parameter int unsigned COORD_BITS = blr_pkg::CoordBits
);
  import blr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [ColorBits-1:0]  pixel_color;
  logic                  last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/blr_step.sv =====
// One Bresenham step: line setup on start, pixel emission and state advance.
// Purely combinational; depends on blr_pkg for dir_t, cmd_e and ColorBits.
`timescale 1ns / 1ps
`default_nettype none

module blr_step #(
  parameter int unsigned COORD_BITS = blr_pkg::CoordBits
) (
  input  logic                    command_i,
  input  logic [COORD_BITS-1:0]   x_start_i,
  input  logic [COORD_BITS-1:0]   y_start_i,
  input  logic [COORD_BITS-1:0]   x_end_i,
  input  logic [COORD_BITS-1:0]   y_end_i,
  input  logic [blr_pkg::ColorBits-1:0] color_i,
  input  logic                    busy_i,
  input  logic [COORD_BITS-1:0]   cur_x_i,
  input  logic [COORD_BITS-1:0]   cur_y_i,
  input  logic signed [COORD_BITS+1:0] err_i,
  input  logic [COORD_BITS-1:0]   abs_dx_i,
  input  logic [COORD_BITS-1:0]   abs_dy_i,
  input  blr_pkg::dir_t           dir_i,
  input  logic [COORD_BITS:0]     pixels_left_i,
  input  logic [blr_pkg::ColorBits-1:0] line_color_i,
  output logic                    emit_o,
  output logic [COORD_BITS-1:0]   pixel_x_o,
  output logic [COORD_BITS-1:0]   pixel_y_o,
  output logic [blr_pkg::ColorBits-1:0] pixel_color_o,
  output logic                    last_o,
  output logic                    busy_o,
  output logic [COORD_BITS-1:0]   cur_x_o,
  output logic [COORD_BITS-1:0]   cur_y_o,
  output logic signed [COORD_BITS+1:0] err_o,
  output logic [COORD_BITS-1:0]   abs_dx_o,
  output logic [COORD_BITS-1:0]   abs_dy_o,
  output blr_pkg::dir_t           dir_o,
  output logic [COORD_BITS:0]     pixels_left_o,
  output logic [blr_pkg::ColorBits-1:0] line_color_o
);
  import blr_pkg::*;

  localparam int unsigned ErrBits = COORD_BITS + 2;
  localparam int unsigned CntBits = COORD_BITS + 1;

  logic                      start;
  dir_t                      new_dir;
  logic [COORD_BITS-1:0]     new_dx;
  logic [COORD_BITS-1:0]     new_dy;
  logic [COORD_BITS-1:0]     new_major;
  logic [COORD_BITS-1:0]     new_minor;
  logic signed [ErrBits-1:0] new_err;

  dir_t                      dir;
  logic [COORD_BITS-1:0]     major;
  logic [COORD_BITS-1:0]     minor;
  logic signed [ErrBits-1:0] err;
  logic [CntBits-1:0]        left;
  logic                      err_pos;
  logic                      step_x;
  logic                      step_y;
  logic signed [ErrBits-1:0] err_sub;

  // line setup
  always_comb begin
    start                   = (command_i == CMD_START);
    new_dir.x_decrement     = x_end_i < x_start_i;
    new_dir.y_decrement     = y_end_i < y_start_i;
    new_dx    = new_dir.x_decrement ? x_start_i - x_end_i : x_end_i - x_start_i;
    new_dy    = new_dir.y_decrement ? y_start_i - y_end_i : y_end_i - y_start_i;
    new_dir.x_major         = new_dx >= new_dy;
    new_major = new_dir.x_major ? new_dx : new_dy;
    new_minor = new_dir.x_major ? new_dy : new_dx;
    new_err   = $signed({2'b00, new_minor}) - $signed({3'b000, new_major[COORD_BITS-1:1]});
  end

  // select fresh setup on start, held line otherwise
  always_comb begin
    emit_o        = start || busy_i;
    pixel_x_o     = start ? x_start_i : cur_x_i;
    pixel_y_o     = start ? y_start_i : cur_y_i;
    pixel_color_o = start ? color_i   : line_color_i;
    abs_dx_o      = start ? new_dx    : abs_dx_i;
    abs_dy_o      = start ? new_dy    : abs_dy_i;
    dir           = start ? new_dir   : dir_i;
    err           = start ? new_err   : err_i;
    left          = start ? {1'b0, new_major} + CntBits'(1) : pixels_left_i;
    line_color_o  = pixel_color_o;
    dir_o         = dir;
  end

  // advance after the emitted pixel
  always_comb begin
    major         = dir.x_major ? abs_dx_o : abs_dy_o;
    minor         = dir.x_major ? abs_dy_o : abs_dx_o;
    last_o        = (left == CntBits'(1));
    pixels_left_o = left - CntBits'(1);
    busy_o        = (pixels_left_o != '0);
    err_pos       = !err[ErrBits-1] && (err != '0);
    step_x        = dir.x_major || err_pos;
    step_y        = !dir.x_major || err_pos;
    cur_x_o       = pixel_x_o;
    cur_y_o       = pixel_y_o;
    if (step_x) begin
      cur_x_o = dir.x_decrement ? pixel_x_o - COORD_BITS'(1) : pixel_x_o + COORD_BITS'(1);
    end
    if (step_y) begin
      cur_y_o = dir.y_decrement ? pixel_y_o - COORD_BITS'(1) : pixel_y_o + COORD_BITS'(1);
    end
    err_sub = err_pos ? $signed({2'b00, major}) : '0;
    err_o   = err - err_sub + $signed({2'b00, minor});
  end

endmodule

`default_nettype wire

// ===== rtl/core/bresenham_line_rasterizer_core.sv =====
// Bresenham line rasterizer top level: command register, step logic, pixel register.
// Depends on blr_pkg, blr_cmd_if / blr_pix_if and blr_step.
//
//   channel  dir  modport  beat
//   cmd      in   sink     start a line (emits first pixel) or ask for the next pixel
//   pix      out  source   one pixel: column, row, color, last flag
//
// One command beat per cycle sustained while pix.ready stays high.
// The command register feeds blr_step, whose result lands in the pixel register;
// line state updates in the same edge, so consecutive commands chain without bubbles.
// Reset clears both valid bits and the busy flag; a next command while idle emits nothing.
// pix.ready low holds a valid pixel and any waiting command; cmd.ready drops only if a command waits.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = blr_pkg::CoordBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  blr_cmd_if.sink   cmd,
  blr_pix_if.source pix
);
  import blr_pkg::*;

  localparam int unsigned ErrBits = COORD_BITS + 2;
  localparam int unsigned CntBits = COORD_BITS + 1;

  // command register
  logic                  cmd_valid_q;
  logic                  command_q;
  logic [COORD_BITS-1:0] x_start_q, y_start_q, x_end_q, y_end_q;
  logic [ColorBits-1:0]  color_q;

  // line state
  logic                      busy_q, busy_d;
  logic [COORD_BITS-1:0]     cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [ErrBits-1:0] err_q, err_d;
  logic [COORD_BITS-1:0]     abs_dx_q, abs_dx_d, abs_dy_q, abs_dy_d;
  dir_t                      dir_q, dir_d;
  logic [CntBits-1:0]        pixels_left_q, pixels_left_d;
  logic [ColorBits-1:0]      line_color_q, line_color_d;

  // pixel register
  logic                  pix_valid_q;
  logic [COORD_BITS-1:0] pixel_x_q, pixel_x_d, pixel_y_q, pixel_y_d;
  logic [ColorBits-1:0]  pixel_color_q, pixel_color_d;
  logic                  last_q, last_d;

  logic emit;
  logic out_free;
  logic advance;

  assign out_free  = !pix_valid_q || pix.ready;
  assign advance   = cmd_valid_q && out_free;
  assign cmd.ready = !cmd_valid_q || out_free;

  blr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .command_i     (command_q),
    .x_start_i     (x_start_q),
    .y_start_i     (y_start_q),
    .x_end_i       (x_end_q),
    .y_end_i       (y_end_q),
    .color_i       (color_q),
    .busy_i        (busy_q),
    .cur_x_i       (cur_x_q),
    .cur_y_i       (cur_y_q),
    .err_i         (err_q),
    .abs_dx_i      (abs_dx_q),
    .abs_dy_i      (abs_dy_q),
    .dir_i         (dir_q),
    .pixels_left_i (pixels_left_q),
    .line_color_i  (line_color_q),
    .emit_o        (emit),
    .pixel_x_o     (pixel_x_d),
    .pixel_y_o     (pixel_y_d),
    .pixel_color_o (pixel_color_d),
    .last_o        (last_d),
    .busy_o        (busy_d),
    .cur_x_o       (cur_x_d),
    .cur_y_o       (cur_y_d),
    .err_o         (err_d),
    .abs_dx_o      (abs_dx_d),
    .abs_dy_o      (abs_dy_d),
    .dir_o         (dir_d),
    .pixels_left_o (pixels_left_d),
    .line_color_o  (line_color_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      pix_valid_q <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      if (cmd.ready) begin
        cmd_valid_q <= cmd.valid;
      end
      if (out_free) begin
        pix_valid_q <= advance && emit;
      end
      if (advance && emit) begin
        busy_q <= busy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.valid && cmd.ready) begin
      command_q <= cmd.command;
      x_start_q <= cmd.x_start;
      y_start_q <= cmd.y_start;
      x_end_q   <= cmd.x_end;
      y_end_q   <= cmd.y_end;
      color_q   <= cmd.color;
    end
    if (advance && emit) begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      err_q         <= err_d;
      abs_dx_q      <= abs_dx_d;
      abs_dy_q      <= abs_dy_d;
      dir_q         <= dir_d;
      pixels_left_q <= pixels_left_d;
      line_color_q  <= line_color_d;
      pixel_x_q     <= pixel_x_d;
      pixel_y_q     <= pixel_y_d;
      pixel_color_q <= pixel_color_d;
      last_q        <= last_d;
    end
  end

  assign pix.valid       = pix_valid_q;
  assign pix.pixel_x     = pixel_x_q;
  assign pix.pixel_y     = pixel_y_q;
  assign pix.pixel_color = pixel_color_q;
  assign pix.last        = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/blr_core_chk.sv =====
// Port-level checks for bresenham_line_rasterizer_core, bound to the top level.
// Depends on blr_pkg for the command codes and color width.
`timescale 1ns / 1ps
`default_nettype none

module blr_core_chk #(
  parameter int unsigned COORD_BITS = blr_pkg::CoordBits
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid_i,
  input logic                          cmd_ready_i,
  input logic                          cmd_command_i,
  input logic                          pix_valid_i,
  input logic                          pix_ready_i,
  input logic [COORD_BITS-1:0]         pix_x_i,
  input logic [COORD_BITS-1:0]         pix_y_i,
  input logic [blr_pkg::ColorBits-1:0] pix_color_i,
  input logic                          pix_last_i
);
  import blr_pkg::*;

  // hold a stalled pixel beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pix_x_i) && $stable(pix_y_i)
      && $stable(pix_color_i) && $stable(pix_last_i))
    else $error("pixel beat changed while stalled");

  // an empty pixel register always takes a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_valid_i |-> cmd_ready_i)
    else $error("command stalled with empty pixel register");

  // a start command is always followed by a valid pixel beat after the command and pixel registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && (cmd_command_i == CMD_START) |=> ##1 pix_valid_i)
    else $error("start command produced no pixel");

endmodule

bind bresenham_line_rasterizer_core blr_core_chk #(
  .COORD_BITS(COORD_BITS)
) u_blr_core_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd.valid),
  .cmd_ready_i   (cmd.ready),
  .cmd_command_i (cmd.command),
  .pix_valid_i   (pix.valid),
  .pix_ready_i   (pix.ready),
  .pix_x_i       (pix.pixel_x),
  .pix_y_i       (pix.pixel_y),
  .pix_color_i   (pix.pixel_color),
  .pix_last_i    (pix.last)
);

`default_nettype wire

// ===== tb/blr_pixel_checker.sv =====
// Pixel checker for the Bresenham line rasterizer: watches the command and pixel channels,
// predicts every pixel a command beat causes and compares it with the pixel beats seen.
// Depends on blr_pkg and the blr_cmd_if / blr_pix_if interfaces.
`timescale 1ns / 1ps

module blr_pixel_checker
  import blr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  blr_cmd_if   cmd,
  blr_pix_if   pix,
  output int   mismatches_o,
  output int   pending_o
);

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [ColorBits-1:0] color;
    logic                 last;
  } pixel_t;

  pixel_t expected_pixels[$];
  int     mismatch_count;
  int     pixel_beats;

  logic [CoordBits-1:0]        cur_x;
  logic [CoordBits-1:0]        cur_y;
  logic [CoordBits-1:0]        abs_dx;
  logic [CoordBits-1:0]        abs_dy;
  logic signed [CoordBits+1:0] err_acc;
  logic [CoordBits:0]          pixels_left;
  logic [ColorBits-1:0]        line_color;
  logic                        busy;
  dir_t                        dir;

  assign mismatches_o = mismatch_count;

  // Emit the current pixel, then advance one Bresenham step.
  task automatic plot_pixel(output pixel_t px);
    logic [CoordBits-1:0] major;
    logic [CoordBits-1:0] minor;
    major = dir.x_major ? abs_dx : abs_dy;
    minor = dir.x_major ? abs_dy : abs_dx;
    px.x     = cur_x;
    px.y     = cur_y;
    px.color = line_color;
    px.last  = (pixels_left == 1);
    pixels_left = pixels_left - 1'b1;
    if (pixels_left == 0) busy = 1'b0;
    if (err_acc > 0) begin
      if (dir.x_major) begin
        cur_y = dir.y_decrement ? cur_y - 1'b1 : cur_y + 1'b1;
      end else begin
        cur_x = dir.x_decrement ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      err_acc = err_acc - $signed({2'b00, major});
    end
    if (dir.x_major) begin
      cur_x = dir.x_decrement ? cur_x - 1'b1 : cur_x + 1'b1;
    end else begin
      cur_y = dir.y_decrement ? cur_y - 1'b1 : cur_y + 1'b1;
    end
    err_acc = err_acc + $signed({2'b00, minor});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t               want;
    pixel_t               got;
    logic [CoordBits-1:0] major;
    logic [CoordBits-1:0] minor;
    if (!rst_ni) begin
      cur_x          = '0;
      cur_y          = '0;
      abs_dx         = '0;
      abs_dy         = '0;
      err_acc        = '0;
      pixels_left    = '0;
      line_color     = '0;
      busy           = 1'b0;
      dir            = '0;
      mismatch_count = 0;
      pixel_beats    = 0;
      expected_pixels.delete();
      pending_o <= 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        if (cmd.command == CMD_START) begin
          line_color      = cmd.color;
          cur_x           = cmd.x_start;
          cur_y           = cmd.y_start;
          dir.x_decrement = cmd.x_end < cmd.x_start;
          dir.y_decrement = cmd.y_end < cmd.y_start;
          abs_dx = dir.x_decrement ? cmd.x_start - cmd.x_end : cmd.x_end - cmd.x_start;
          abs_dy = dir.y_decrement ? cmd.y_start - cmd.y_end : cmd.y_end - cmd.y_start;
          dir.x_major = abs_dx >= abs_dy;
          major   = dir.x_major ? abs_dx : abs_dy;
          minor   = dir.x_major ? abs_dy : abs_dx;
          err_acc = $signed({2'b00, minor}) - $signed({3'b000, major[CoordBits-1:1]});
          pixels_left = {1'b0, major} + 1'b1;
          busy = 1'b1;
          plot_pixel(want);
          expected_pixels.push_back(want);
        end else if (busy) begin
          plot_pixel(want);
          expected_pixels.push_back(want);
        end
      end
      if (pix.valid && pix.ready) begin
        got = '{pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last};
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("pixel beat %0d: unexpected (%0d,%0d) color %h last %b",
                     pixel_beats, got.x, got.y, got.color, got.last);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("pixel beat %0d: expected (%0d,%0d) color %h last %b, got (%0d,%0d) color %h last %b",
                       pixel_beats, want.x, want.y, want.color, want.last,
                       got.x, got.y, got.color, got.last);
            end
          end
        end
        pixel_beats++;
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

// ===== tb/tb_bresenham_line_rasterizer_core.sv =====
// Testbench top for bresenham_line_rasterizer_core: drives line commands with random gaps
// and output stalls, and gives the verdict from the failure count of blr_pixel_checker.
// Depends on blr_pkg, blr_if.sv, the core and tb/blr_pixel_checker.sv.
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer_core;
  import blr_pkg::*;

  localparam int MaxCoord = (1 << CoordBits) - 1;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm;
  bit   line_open;
  int   fed_items;
  int   mismatches;
  int   pending;

  blr_cmd_if cmd_bus ();
  blr_pix_if pix_bus ();

  bresenham_line_rasterizer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd    (cmd_bus),
    .pix    (pix_bus)
  );

  blr_pixel_checker u_pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd          (cmd_bus),
    .pix          (pix_bus),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return MaxCoord;
    return $urandom_range(0, MaxCoord);
  endfunction

  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(0, 12);
    if (r < 98) return $urandom_range(13, 200);
    return $urandom_range(201, MaxCoord);
  endfunction

  // Place an endpoint span away from base, turning back at the edges.
  function automatic int offset_coord(int base, int span);
    int sum;
    sum = $urandom_range(0, 1) ? base + span : base - span;
    if (sum > MaxCoord) sum = base - span;
    if (sum < 0) sum = base + span;
    if (sum > MaxCoord) sum = MaxCoord;
    return sum;
  endfunction

  task automatic send_beat(input cmd_e op, input int xs, input int ys, input int xe,
                           input int ye, input int c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= op;
    cmd_bus.x_start <= CoordBits'(xs);
    cmd_bus.y_start <= CoordBits'(ys);
    cmd_bus.x_end   <= CoordBits'(xe);
    cmd_bus.y_end   <= CoordBits'(ye);
    cmd_bus.color   <= ColorBits'(c);
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  task automatic send_idle_next();
    send_beat(CMD_NEXT, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Start a line and walk it; a cut above 0 and below its pixel count stops early so the next start abandons it.
  task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                           input int c, input int cut);
    int dx;
    int dy;
    int beats;
    dx = (xs > xe) ? xs - xe : xe - xs;
    dy = (ys > ye) ? ys - ye : ye - ys;
    beats = ((dx > dy) ? dx : dy) + 1;
    line_open = (cut > 0 && cut < beats);
    if (line_open) beats = cut;
    send_beat(CMD_START, xs, ys, xe, ye, c);
    for (int i = 1; i < beats; i++) send_idle_next();
    fed_items += beats;
  endtask

  initial begin
    int on_len;
    int off_len;
    forever begin
      on_len = $urandom_range(1, 16);
      pix_bus.ready <= 1'b1;
      repeat (on_len) @(posedge clk_i);
      off_len = pick_gap();
      if (off_len > 0) begin
        pix_bus.ready <= 1'b0;
        repeat (off_len) @(posedge clk_i);
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int oct_dx[8];
    int oct_dy[8];
    int xs;
    int ys;
    int pixels;
    int cut;
    oct_dx = '{2, 1, -1, -2, -2, -1, 1, 2};
    oct_dy = '{1, 2, 2, 1, -1, -2, -2, -1};
    rst_ni          <= 1'b0;
    cmd_bus.valid   <= 1'b0;
    cmd_bus.command <= CMD_START;
    cmd_bus.x_start <= '0;
    cmd_bus.y_start <= '0;
    cmd_bus.x_end   <= '0;
    cmd_bus.y_end   <= '0;
    cmd_bus.color   <= '0;
    calm      = 1'b0;
    line_open = 1'b0;
    fed_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // next while idle, single points at both corners, then each octant
    send_idle_next();
    draw_line(0, 0, 0, 0, 16'h0000, 0);
    draw_line(MaxCoord, MaxCoord, MaxCoord, MaxCoord, 16'hFFFF, 0);
    for (int i = 0; i < 8; i++) begin
      draw_line(1024, 1024, 1024 + oct_dx[i], 1024 + oct_dy[i], $urandom, 0);
    end
    // full-range diagonals, each abandoned by the next start
    draw_line(0, 0, MaxCoord, MaxCoord, 16'hFFFF, 2);
    draw_line(MaxCoord, 0, 0, MaxCoord, 16'h0000, 2);

    while (fed_items < 1400) begin
      calm = ($urandom_range(0, 4) == 0);
      if (!line_open && $urandom_range(0, 99) < 6) begin
        send_idle_next();
      end else begin
        xs = pick_coord();
        ys = pick_coord();
        xs = xs;
        cut = 0;
        begin : make_line
          int xe;
          int ye;
          xe = offset_coord(xs, pick_span());
          ye = offset_coord(ys, pick_span());
          pixels = (((xs > xe) ? xs - xe : xe - xs) > ((ys > ye) ? ys - ye : ye - ys)) ?
                   ((xs > xe) ? xs - xe : xe - xs) + 1 : ((ys > ye) ? ys - ye : ye - ys) + 1;
          if (pixels > 150) cut = $urandom_range(1, 150);
          else if ($urandom_range(0, 99) < 12) cut = $urandom_range(1, pixels);
          draw_line(xs, ys, xe, ye, $urandom, cut);
        end
      end
    end

    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
